FILE: design/sprx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Sprite pixel expander package
// Shared types, opcodes, default sizes and small helper functions.
// ---------------------------------------------------------------------------
package sprx_pkg;

	localparam int PALETTE_DEPTH_DEF  = 512;
	localparam int SURFACE_WIDTH_DEF  = 2048;
	localparam int SURFACE_HEIGHT_DEF = 1024;

	localparam int PAL_ENTRY_W = 25;

	localparam logic [1:0] OP_PAL    = 2'd0;
	localparam logic [1:0] OP_SPRITE = 2'd1;
	localparam logic [1:0] OP_DATA   = 2'd2;

	typedef enum logic {
		ST_IDLE,
		ST_EXPAND
	} seq_state_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [8:0]  pal_index;
		logic [15:0] pal_color;
		logic [10:0] pos_x;
		logic [9:0]  pos_y;
		logic [1:0]  scale_x;
		logic [1:0]  scale_y;
		logic [7:0]  width_m1;
		logic [7:0]  height_m1;
		logic [2:0]  depth_m1;
		logic [4:0]  pal_bank;
		logic [63:0] data_word;
	} cmd_t;

	typedef struct packed {
		logic [11:0] pix_x;
		logic [10:0] pix_y;
		logic [1:0]  rep_x;
		logic [1:0]  rep_y;
		logic [23:0] pix_color;
		logic        opaque;
		logic        last;
		logic        sprite_done;
	} pix_t;

	// Per-pixel data that travels alongside the palette read.
	typedef struct packed {
		logic [11:0] pix_x;
		logic [10:0] pix_y;
		logic [1:0]  rep_x;
		logic [1:0]  rep_y;
		logic        last;
		logic        sprite_done;
	} pix_meta_t;

	function automatic logic [7:0] expand5(logic [4:0] c);
		return {c, c[4:2]};
	endfunction

	// Bit 15 set stores a transparent zero entry.
	function automatic logic [PAL_ENTRY_W-1:0] pal_entry(logic [15:0] c);
		if (c[15])
			return '0;
		return {1'b1, expand5(c[4:0]), expand5(c[9:5]), expand5(c[14:10])};
	endfunction

	function automatic logic [6:0] per_word(logic [3:0] bpp);
		logic [6:0] n;
		unique case (bpp)
			4'd1:    n = 7'd64;
			4'd2:    n = 7'd32;
			4'd3:    n = 7'd21;
			4'd4:    n = 7'd16;
			4'd5:    n = 7'd12;
			4'd6:    n = 7'd10;
			4'd7:    n = 7'd9;
			4'd8:    n = 7'd8;
			default: n = 7'd64;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] pix_mask(logic [3:0] bpp);
		logic [8:0] m;
		m = (9'd1 << bpp) - 9'd1;
		return m[7:0];
	endfunction

	function automatic logic [8:0] clip_size(logic [12:0] pos, logic [8:0] size,
			logic [12:0] limit);
		logic [13:0] sum;
		logic [12:0] room;
		sum  = {1'b0, pos} + {5'b0, size};
		room = limit - pos;
		if (pos >= limit)
			return '0;
		if (sum > {1'b0, limit})
			return room[8:0];
		return size;
	endfunction

	// Remainder of v by d for v below 32 * d: five restoring steps.
	function automatic logic [15:0] mod_depth(logic [15:0] v, logic [15:0] d);
		logic [15:0] r;
		r = v;
		for (int i = 4; i >= 0; i--) begin
			if (r >= (d << i))
				r = r - (d << i);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: design/sprx_palette.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Sprite palette memory
// Single-port-write, registered-read palette with a clearing sweep after reset.
// ---------------------------------------------------------------------------
module sprx_palette #(
	parameter int PALETTE_DEPTH = sprx_pkg::PALETTE_DEPTH_DEF,
	localparam int IDX_W = $clog2(PALETTE_DEPTH)
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               wr_en,
	input  wire logic [IDX_W-1:0]                   wr_addr,
	input  wire logic [sprx_pkg::PAL_ENTRY_W-1:0]   wr_data,
	input  wire logic                               rd_en,
	input  wire logic [IDX_W-1:0]                   rd_addr,
	output logic      [sprx_pkg::PAL_ENTRY_W-1:0]   rd_data,
	output logic                                    clearing
);

	localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(PALETTE_DEPTH - 1);

	logic [sprx_pkg::PAL_ENTRY_W-1:0] mem [PALETTE_DEPTH];
	logic                              clr_q;
	logic [IDX_W-1:0]                  clr_addr_q;
	logic                              we;
	logic [IDX_W-1:0]                  wa;
	logic [sprx_pkg::PAL_ENTRY_W-1:0]  wd;

	// Sweep every entry to transparent zero, one per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == LAST_ADDR)
				clr_q <= 1'b0;
		end
	end

	always_comb begin
		we = clr_q | wr_en;
		wa = clr_q ? clr_addr_q : wr_addr;
		wd = clr_q ? '0 : wr_data;
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

	assign clearing = clr_q;

endmodule
`default_nettype wire

FILE: design/sprx_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Sprite sequencer
// Holds sprite state, decodes commands and steps through a data word's pixels.
// ---------------------------------------------------------------------------
module sprx_sequencer #(
	parameter int PALETTE_DEPTH  = sprx_pkg::PALETTE_DEPTH_DEF,
	parameter int SURFACE_WIDTH  = sprx_pkg::SURFACE_WIDTH_DEF,
	parameter int SURFACE_HEIGHT = sprx_pkg::SURFACE_HEIGHT_DEF,
	localparam int IDX_W = $clog2(PALETTE_DEPTH)
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cmd_fire,
	input  wire sprx_pkg::cmd_t                   cmd,
	input  wire logic                             issue_ok,
	output logic                                  busy,
	output logic                                  rd_en,
	output logic      [IDX_W-1:0]                 rd_addr,
	output sprx_pkg::pix_meta_t                   meta,
	output logic                                  wr_en,
	output logic      [IDX_W-1:0]                 wr_addr,
	output logic      [sprx_pkg::PAL_ENTRY_W-1:0] wr_data
);

	localparam int IW1 = IDX_W + 1;
	localparam logic [12:0] SURF_W  = 13'(SURFACE_WIDTH);
	localparam logic [12:0] SURF_H  = 13'(SURFACE_HEIGHT);
	localparam logic [15:0] DEP16   = 16'(PALETTE_DEPTH);
	localparam logic [10:0] DEP11   = 11'(PALETTE_DEPTH);
	localparam logic [IDX_W:0] DEP_I = IW1'(PALETTE_DEPTH);

	sprx_pkg::seq_state_t state_q, state_d;

	// Latched sprite description.
	logic [10:0]       left_q;
	logic [9:0]        top_q;
	logic [1:0]        sx_q, sy_q;
	logic [8:0]        cw_q, ch_q;
	logic [2:0]        dm1_q;
	logic [IDX_W-1:0]  base_q;
	logic [8:0]        row_q, col_q;
	logic              active_q;

	// Word being expanded.
	logic [63:0]       word_q;
	logic [6:0]        rem_q;
	logic [11:0]       x_q;
	logic [10:0]       y_q;
	logic              done_q;

	logic [3:0]        bpp_q, bpp_in;
	logic [6:0]        per;
	logic [8:0]        left_w, n_w;
	logic [9:0]        col_end, row_nxt;
	logic              row_end, spr_done;
	logic              data_go, data_empty, sprite_go;
	logic [8:0]        cw_d, ch_d;
	logic [15:0]       base16;
	logic [10:0]       pidx;
	logic [7:0]        pix8;
	logic [IDX_W:0]    isum;

	assign bpp_q  = {1'b0, dm1_q} + 4'd1;
	assign bpp_in = {1'b0, cmd.depth_m1} + 4'd1;

	// Pixels this word yields: min(pixels per word, pixels left in the row).
	always_comb begin
		per      = sprx_pkg::per_word(bpp_q);
		left_w   = (cw_q > col_q) ? (cw_q - col_q) : 9'd0;
		n_w      = (left_w < {2'b0, per}) ? left_w : {2'b0, per};
		col_end  = {1'b0, col_q} + {1'b0, n_w};
		row_nxt  = {1'b0, row_q} + 10'd1;
		row_end  = col_end >= {1'b0, cw_q};
		spr_done = row_end && (row_nxt >= {1'b0, ch_q});
	end

	always_comb begin
		data_go    = cmd_fire && (cmd.opcode == sprx_pkg::OP_DATA) && active_q;
		data_empty = data_go && (n_w == 9'd0);
		sprite_go  = cmd_fire && (cmd.opcode == sprx_pkg::OP_SPRITE);
		cw_d   = sprx_pkg::clip_size({2'b0, cmd.pos_x}, {1'b0, cmd.width_m1} + 9'd1, SURF_W);
		ch_d   = sprx_pkg::clip_size({3'b0, cmd.pos_y}, {1'b0, cmd.height_m1} + 9'd1, SURF_H);
		base16 = sprx_pkg::mod_depth(16'({8'b0, cmd.pal_bank} << bpp_in), DEP16);
	end

	// Palette write: fold the index into the palette, convert the color.
	always_comb begin
		pidx    = {2'b0, cmd.pal_index};
		if (pidx >= DEP11)
			pidx = pidx - DEP11;
		wr_en   = cmd_fire && (cmd.opcode == sprx_pkg::OP_PAL);
		wr_addr = pidx[IDX_W-1:0];
		wr_data = sprx_pkg::pal_entry(cmd.pal_color);
	end

	// Palette read address: bank base plus pixel, wrapped once.
	always_comb begin
		pix8 = word_q[7:0] & sprx_pkg::pix_mask(bpp_q);
		isum = {1'b0, base_q} + IW1'(pix8);
		if (isum >= DEP_I)
			isum = isum - DEP_I;
		rd_addr = isum[IDX_W-1:0];
	end

	always_comb begin
		meta.pix_x       = x_q;
		meta.pix_y       = y_q;
		meta.rep_x       = sx_q;
		meta.rep_y       = sy_q;
		meta.last        = (rem_q == 7'd1);
		meta.sprite_done = (rem_q == 7'd1) && done_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= sprx_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		unique case (state_q)
			sprx_pkg::ST_IDLE: begin
				if (data_go && !data_empty)
					state_d = sprx_pkg::ST_EXPAND;
			end
			sprx_pkg::ST_EXPAND: begin
				if (issue_ok) begin
					rd_en = 1'b1;
					if (rem_q == 7'd1)
						state_d = sprx_pkg::ST_IDLE;
				end
			end
			default: state_d = sprx_pkg::ST_IDLE;
		endcase
	end

	assign busy = (state_q == sprx_pkg::ST_EXPAND);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			top_q    <= '0;
			sx_q     <= '0;
			sy_q     <= '0;
			cw_q     <= '0;
			ch_q     <= '0;
			dm1_q    <= '0;
			base_q   <= '0;
			row_q    <= '0;
			col_q    <= '0;
			active_q <= 1'b0;
			rem_q    <= '0;
			done_q   <= 1'b0;
		end else if (sprite_go) begin
			left_q   <= cmd.pos_x;
			top_q    <= cmd.pos_y;
			sx_q     <= cmd.scale_x;
			sy_q     <= cmd.scale_y;
			cw_q     <= cw_d;
			ch_q     <= ch_d;
			dm1_q    <= cmd.depth_m1;
			base_q   <= base16[IDX_W-1:0];
			row_q    <= '0;
			col_q    <= '0;
			active_q <= (cw_d != 9'd0) && (ch_d != 9'd0);
		end else if (data_empty) begin
			// counters out of step: close the row with no pixels
			col_q <= '0;
			row_q <= row_nxt[8:0];
			if (row_nxt >= {1'b0, ch_q})
				active_q <= 1'b0;
		end else if (data_go) begin
			rem_q  <= n_w[6:0];
			done_q <= spr_done;
			if (row_end) begin
				col_q <= '0;
				row_q <= row_nxt[8:0];
				if (spr_done)
					active_q <= 1'b0;
			end else begin
				col_q <= col_end[8:0];
			end
		end else if (rd_en) begin
			rem_q <= rem_q - 7'd1;
		end
	end

	// Word payload: load on a data transfer, shift one pixel per read.
	always_ff @(posedge clk) begin
		if (data_go && !data_empty) begin
			word_q <= cmd.data_word;
			x_q    <= 12'(left_q) + 12'(col_q) * 12'(sx_q);
			y_q    <= 11'(top_q) + 11'(row_q) * 11'(sy_q);
		end else if (rd_en) begin
			word_q <= word_q >> bpp_q;
			x_q    <= x_q + 12'(sx_q);
		end
	end

endmodule
`default_nettype wire

FILE: design/sprite_pixel_expander.sv
// Path: each pixel passes the palette read stage, then the output register, then pix.
// Throughput: one pixel per cycle from the palette read port while pix_stall is low;
//   a data word (n pixels, up to 64) stalls commands until all its pixels are read.
// Reset: arst_n clears control state; the palette then sweeps its PALETTE_DEPTH entries
//   (512 by default) to transparent zero with cmd_stall high.
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Sprite pixel expander
// Turns palette writes, sprite starts and packed pixel words into one
// colored, positioned result per source pixel.
// ---------------------------------------------------------------------------
module sprite_pixel_expander #(
	parameter int PALETTE_DEPTH  = sprx_pkg::PALETTE_DEPTH_DEF,
	parameter int SURFACE_WIDTH  = sprx_pkg::SURFACE_WIDTH_DEF,
	parameter int SURFACE_HEIGHT = sprx_pkg::SURFACE_HEIGHT_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cmd_valid,
	output logic                cmd_stall,
	input  wire sprx_pkg::cmd_t cmd,
	output logic                pix_valid,
	input  wire logic           pix_stall,
	output sprx_pkg::pix_t      pix
);

	localparam int IDX_W = $clog2(PALETTE_DEPTH);

	logic                             cmd_fire;
	logic                             seq_busy;
	logic                             pal_clearing;
	logic                             rd_en;
	logic [IDX_W-1:0]                 rd_addr;
	logic [sprx_pkg::PAL_ENTRY_W-1:0] rd_data;
	logic                             wr_en;
	logic [IDX_W-1:0]                 wr_addr;
	logic [sprx_pkg::PAL_ENTRY_W-1:0] wr_data;
	sprx_pkg::pix_meta_t              meta;

	// Read stage: meta for the palette read in flight.
	logic                             valid_s1;
	sprx_pkg::pix_meta_t              meta_s1;

	// Output register.
	logic                             pix_valid_q;
	sprx_pkg::pix_t                   pix_q;

	logic                             out_adv;
	logic                             s1_adv;

	// Hold commands while a word is being expanded or the palette is clearing.
	assign cmd_stall = seq_busy | pal_clearing;
	assign cmd_fire  = cmd_valid & ~cmd_stall;

	// The output register frees up when empty or when its transfer completes;
	// the read stage advances whenever the output register can take it, so
	// the palette read data is only refreshed when the previous read has moved on.
	assign out_adv = ~pix_valid_q | ~pix_stall;
	assign s1_adv  = ~valid_s1 | out_adv;

	sprx_sequencer #(
		.PALETTE_DEPTH  (PALETTE_DEPTH),
		.SURFACE_WIDTH  (SURFACE_WIDTH),
		.SURFACE_HEIGHT (SURFACE_HEIGHT)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_fire (cmd_fire),
		.cmd      (cmd),
		.issue_ok (s1_adv),
		.busy     (seq_busy),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.meta     (meta),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data)
	);

	sprx_palette #(
		.PALETTE_DEPTH (PALETTE_DEPTH)
	) u_pal (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.clearing (pal_clearing)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			pix_valid_q <= 1'b0;
		end else begin
			if (s1_adv)
				valid_s1 <= rd_en;
			if (out_adv)
				pix_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && rd_en)
			meta_s1 <= meta;
		// Merge the pixel's meta with the palette entry as it moves out.
		if (out_adv && valid_s1) begin
			pix_q.pix_x       <= meta_s1.pix_x;
			pix_q.pix_y       <= meta_s1.pix_y;
			pix_q.rep_x       <= meta_s1.rep_x;
			pix_q.rep_y       <= meta_s1.rep_y;
			pix_q.pix_color   <= rd_data[23:0];
			pix_q.opaque      <= rd_data[24];
			pix_q.last        <= meta_s1.last;
			pix_q.sprite_done <= meta_s1.sprite_done;
		end
	end

	assign pix_valid = pix_valid_q;
	assign pix       = pix_q;

endmodule
`default_nettype wire

FILE: design/sprx_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Sprite pixel expander port checker
// Watches the result channel for ordering and payload consistency.
// ---------------------------------------------------------------------------
module sprx_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           cmd_valid,
	input wire logic           cmd_stall,
	input wire sprx_pkg::cmd_t cmd,
	input wire logic           pix_valid,
	input wire logic           pix_stall,
	input wire sprx_pkg::pix_t pix
);

	logic cmd_seen;
	assign cmd_seen = cmd_valid & ~cmd_stall & (cmd.opcode == sprx_pkg::OP_DATA);

	// A stalled result holds.
	a_pix_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_stall |=> pix_valid && $stable(pix))
		else $error("result changed while stalled");

	// Sprite end closes a word.
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix.sprite_done |-> pix.last)
		else $error("sprite_done without last");

	// Pixels of one word share a row and step by the repeat count.
	a_word_step: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_stall && !pix.last && !cmd_seen |=> !pix_valid ||
		(pix.pix_y == $past(pix.pix_y) &&
		 pix.pix_x == $past(pix.pix_x) + 12'($past(pix.rep_x))))
		else $error("pixel step broken inside a word");

	// Transparent entries carry no color.
	a_transp: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix.opaque |-> pix.pix_color == 24'd0)
		else $error("transparent pixel with color");

endmodule

bind sprite_pixel_expander sprx_checker u_sprx_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_stall (cmd_stall),
	.cmd       (cmd),
	.pix_valid (pix_valid),
	.pix_stall (pix_stall),
	.pix       (pix)
);
`default_nettype wire

FILE: dv/tb_sprite_pixel_expander.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sprite pixel expander testbench
// Drives palette writes, sprite starts and pixel words into the expander and
// checks every pixel against an in-bench predictor. A short table of
// directed commands comes first, some with hand-written pixels, then random
// well-formed sprites with stray commands mixed in, under random stalls.
// ---------------------------------------------------------------------------
module tb_sprite_pixel_expander;
	import sprx_pkg::*;

	localparam int PAL_DEPTH    = PALETTE_DEPTH_DEF;
	localparam int SURF_W       = SURFACE_WIDTH_DEF;
	localparam int SURF_H       = SURFACE_HEIGHT_DEF;
	localparam int ITEM_TARGET  = 270;
	localparam int WATCHDOG_MAX = 4000;
	localparam int LONG_HOLD    = 400;
	localparam int DRAIN_CYCLES = 10;

	// opcode 3 has no meaning; the block must drop it
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// One line of the directed table. When hand_checked is set, the single
	// pixel in want replaces whatever the predictor works out.
	typedef struct {
		cmd_t c;
		bit   hand_checked;
		pix_t want;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic pix_valid;
	logic pix_stall;
	pix_t pix;

	sprite_pixel_expander DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pix(pix)
	);

	// Predictor state: palette plus the latched sprite and its raster position.
	logic [24:0] pal_mem [PAL_DEPTH];
	logic [10:0] spr_left;
	logic [9:0]  spr_top;
	logic [1:0]  spr_sx;
	logic [1:0]  spr_sy;
	logic [8:0]  spr_w;
	logic [8:0]  spr_h;
	logic [3:0]  spr_depth;
	logic [4:0]  spr_bank;
	logic [8:0]  spr_row;
	logic [8:0]  spr_col;
	logic        spr_active;

	pix_t pending_pixels[$];  // pixels owed by the block, oldest first
	pix_t word_pixels[$];     // pixels the last command produced

	int  mismatches;
	int  items_done;
	int  quiet_cycles;
	bit  calm;         // no idling on either side
	bit  pressure_go;  // ask the receiver for one long hold-off

	// -----------------------------------------------------------------------
	// Clock
	// -----------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// -----------------------------------------------------------------------
	// Predictor
	// -----------------------------------------------------------------------
	function automatic logic [7:0] widen5(logic [4:0] c);
		return 8'((int'(c) << 3) | (int'(c) >> 2));
	endfunction

	// Clip a size so the sprite stays on the surface.
	function automatic int clip_extent(int pos, int size, int limit);
		if (pos >= limit)
			return 0;
		if (pos + size > limit)
			return limit - pos;
		return size;
	endfunction

	task automatic clear_model();
		for (int i = 0; i < PAL_DEPTH; i++)
			pal_mem[i] = '0;
		spr_left   = '0;
		spr_top    = '0;
		spr_sx     = '0;
		spr_sy     = '0;
		spr_w      = '0;
		spr_h      = '0;
		spr_depth  = 4'd1;
		spr_bank   = '0;
		spr_row    = '0;
		spr_col    = '0;
		spr_active = 1'b0;
	endtask

	// Advance the predictor by one command and leave its pixels in word_pixels.
	task automatic expand_command(input cmd_t c);
		int          bpp;
		int          mask;
		int          cap;
		int          remain;
		int          n;
		int          idx;
		bit          row_end;
		bit          done;
		logic [63:0] bits;
		logic [24:0] e;
		pix_t        p;
		word_pixels.delete();
		case (c.opcode)
			OP_PAL: begin
				if (c.pal_color[15])
					pal_mem[c.pal_index] = '0;
				else
					pal_mem[c.pal_index] = {1'b1, widen5(c.pal_color[4:0]),
						widen5(c.pal_color[9:5]), widen5(c.pal_color[14:10])};
			end
			OP_SPRITE: begin
				spr_left   = c.pos_x;
				spr_top    = c.pos_y;
				spr_sx     = c.scale_x;
				spr_sy     = c.scale_y;
				spr_w      = 9'(clip_extent(int'(c.pos_x), int'(c.width_m1) + 1, SURF_W));
				spr_h      = 9'(clip_extent(int'(c.pos_y), int'(c.height_m1) + 1, SURF_H));
				spr_depth  = {1'b0, c.depth_m1} + 4'd1;
				spr_bank   = c.pal_bank;
				spr_row    = '0;
				spr_col    = '0;
				spr_active = (spr_w != 0) && (spr_h != 0);
			end
			OP_DATA: begin
				if (spr_active) begin
					bpp = int'(spr_depth);
					if (bpp < 1 || bpp > 8)
						bpp = 1;
					mask   = (1 << bpp) - 1;
					cap    = 64 / bpp;
					remain = (spr_w > spr_col) ? int'(spr_w) - int'(spr_col) : 0;
					n      = (remain < cap) ? remain : cap;
					if (n == 0) begin
						// counters out of step: close the row silently
						spr_col = '0;
						spr_row = spr_row + 9'd1;
						if (spr_row >= spr_h)
							spr_active = 1'b0;
					end else begin
						row_end = (int'(spr_col) + n >= int'(spr_w));
						done    = row_end && (int'(spr_row) + 1 >= int'(spr_h));
						bits    = c.data_word;
						for (int k = 0; k < n; k++) begin
							idx = ((int'(spr_bank) << bpp) | (int'(bits[7:0]) & mask)) % PAL_DEPTH;
							e   = pal_mem[idx];
							p.pix_x       = 12'(int'(spr_left) + (int'(spr_col) + k) * int'(spr_sx));
							p.pix_y       = 11'(int'(spr_top) + int'(spr_row) * int'(spr_sy));
							p.rep_x       = spr_sx;
							p.rep_y       = spr_sy;
							p.pix_color   = e[23:0];
							p.opaque      = e[24];
							p.last        = (k + 1 == n);
							p.sprite_done = (k + 1 == n) && done;
							word_pixels.push_back(p);
							bits = bits >> bpp;
						end
						if (row_end) begin
							spr_col = '0;
							spr_row = spr_row + 9'd1;
							if (done)
								spr_active = 1'b0;
						end else begin
							spr_col = spr_col + 9'(n);
						end
					end
				end
			end
			default: begin
			end
		endcase
	endtask

	// -----------------------------------------------------------------------
	// Command builders: unused fields carry random bits
	// -----------------------------------------------------------------------
	function automatic cmd_t noise_cmd(logic [1:0] op);
		logic [159:0] r;
		cmd_t c;
		r = {$urandom, $urandom, $urandom, $urandom, $urandom};
		c = r[$bits(cmd_t)-1:0];
		c.opcode = op;
		return c;
	endfunction

	function automatic cmd_t pal_cmd(int idx, int color);
		cmd_t c;
		c = noise_cmd(OP_PAL);
		c.pal_index = 9'(idx);
		c.pal_color = 16'(color);
		return c;
	endfunction

	function automatic cmd_t spr_cmd(int x, int y, int sx, int sy, int w, int h,
			int d, int bank);
		cmd_t c;
		c = noise_cmd(OP_SPRITE);
		c.pos_x     = 11'(x);
		c.pos_y     = 10'(y);
		c.scale_x   = 2'(sx);
		c.scale_y   = 2'(sy);
		c.width_m1  = 8'(w);
		c.height_m1 = 8'(h);
		c.depth_m1  = 3'(d);
		c.pal_bank  = 5'(bank);
		return c;
	endfunction

	function automatic cmd_t data_cmd(logic [63:0] word);
		cmd_t c;
		c = noise_cmd(OP_DATA);
		c.data_word = word;
		return c;
	endfunction

	// -----------------------------------------------------------------------
	// Sender: present one command, hold it until the transfer, then predict.
	// Call and return at a falling edge.
	// -----------------------------------------------------------------------
	task automatic send_cmd(input cmd_t c, input bit hand_checked = 1'b0,
			input pix_t want = '0);
		int gap;
		if (!calm && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 14);
			cmd_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd       <= c;
		cmd_valid <= 1'b1;
		// transfer happens at the first rising edge with stall low
		do @(posedge clk); while (cmd_stall !== 1'b0);
		// count only commands the block does something with
		if (c.opcode == OP_PAL || c.opcode == OP_SPRITE || (c.opcode == OP_DATA && spr_active))
			items_done++;
		expand_command(c);
		if (hand_checked)
			pending_pixels.push_back(want);
		else
			foreach (word_pixels[i])
				pending_pixels.push_back(word_pixels[i]);
		@(negedge clk);
	endtask

	// -----------------------------------------------------------------------
	// Receiver stall: short random bursts, one long hold-off on request,
	// nothing once the run turns calm.
	// -----------------------------------------------------------------------
	initial begin : rx_stall
		int  stall_left;
		bit  pressure_used;
		stall_left    = 0;
		pressure_used = 1'b0;
		pix_stall     = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left == 0) begin
				if (pressure_go && !pressure_used) begin
					pressure_used = 1'b1;
					stall_left    = LONG_HOLD;
				end else if (!calm && $urandom_range(0, 5) == 0) begin
					stall_left = $urandom_range(1, 14);
				end
			end
			if (stall_left != 0) begin
				pix_stall <= 1'b1;
				stall_left--;
			end else begin
				pix_stall <= 1'b0;
			end
		end
	end

	// -----------------------------------------------------------------------
	// Pixel checker and watchdog
	// -----------------------------------------------------------------------
	always @(posedge clk) begin : pixel_check
		pix_t want;
		if (arst_n === 1'b1 && pix_valid === 1'b1 && pix_stall === 1'b0) begin
			if (pending_pixels.size() == 0) begin
				$error("pixel transfer with none expected: x=%0d y=%0d", pix.pix_x, pix.pix_y);
				mismatches++;
			end else begin
				want = pending_pixels.pop_front();
				if (pix.pix_x !== want.pix_x) begin
					$error("pix_x expected %0d got %0d", want.pix_x, pix.pix_x);
					mismatches++;
				end
				if (pix.pix_y !== want.pix_y) begin
					$error("pix_y expected %0d got %0d", want.pix_y, pix.pix_y);
					mismatches++;
				end
				if (pix.rep_x !== want.rep_x) begin
					$error("rep_x expected %0d got %0d", want.rep_x, pix.rep_x);
					mismatches++;
				end
				if (pix.rep_y !== want.rep_y) begin
					$error("rep_y expected %0d got %0d", want.rep_y, pix.rep_y);
					mismatches++;
				end
				if (pix.pix_color !== want.pix_color) begin
					$error("pix_color expected %06h got %06h", want.pix_color, pix.pix_color);
					mismatches++;
				end
				if (pix.opaque !== want.opaque) begin
					$error("opaque expected %0b got %0b", want.opaque, pix.opaque);
					mismatches++;
				end
				if (pix.last !== want.last) begin
					$error("last expected %0b got %0b", want.last, pix.last);
					mismatches++;
				end
				if (pix.sprite_done !== want.sprite_done) begin
					$error("sprite_done expected %0b got %0b", want.sprite_done, pix.sprite_done);
					mismatches++;
				end
			end
		end
		// watchdog: any transfer on either side counts as progress
		if ((cmd_valid === 1'b1 && cmd_stall === 1'b0) || (pix_valid === 1'b1 && pix_stall === 1'b0))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_MAX) begin
			$error("no transfer for %0d cycles, %0d pixels outstanding",
				quiet_cycles, pending_pixels.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// -----------------------------------------------------------------------
	// Stimulus
	// -----------------------------------------------------------------------
	initial begin : stimulus
		plan_row_t plan[$];
		int        budget;
		int        x;
		int        y;
		int        w;
		int        h;

		mismatches   = 0;
		items_done   = 0;
		quiet_cycles = 0;
		calm         = 1'b0;
		pressure_go  = 1'b0;
		arst_n       = 1'b0;
		cmd_valid    = 1'b0;
		cmd          = '0;
		clear_model();

		// Hold reset at the start; the palette sweep afterwards shows up
		// as cmd_stall and is waited out by the handshake.
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Directed table. Hand-written pixels only where the value is obvious:
		// the reset palette, and the far corner with the top palette entry.
		plan.push_back('{data_cmd('1), 1'b0, '0});                    // no sprite: drop
		plan.push_back('{spr_cmd(0, 0, 1, 1, 0, 0, 7, 0), 1'b0, '0});
		plan.push_back('{data_cmd('0), 1'b1,
			pix_t'({12'd0, 11'd0, 2'd1, 2'd1, 24'h000000, 1'b0, 1'b1, 1'b1})});
		plan.push_back('{pal_cmd(511, 'h7fff), 1'b0, '0});
		plan.push_back('{pal_cmd(0, 'h0000), 1'b0, '0});
		plan.push_back('{pal_cmd(1, 'hffff), 1'b0, '0});             // transparent
		plan.push_back('{pal_cmd(2, 'h001f), 1'b0, '0});
		plan.push_back('{pal_cmd(3, 'h03e0), 1'b0, '0});
		plan.push_back('{pal_cmd(4, 'h7c00), 1'b0, '0});
		plan.push_back('{spr_cmd(2047, 1023, 3, 3, 0, 0, 7, 31), 1'b0, '0});
		plan.push_back('{data_cmd(64'hff), 1'b1,
			pix_t'({12'd2047, 11'd1023, 2'd3, 2'd3, 24'hffffff, 1'b1, 1'b1, 1'b1})});
		// one bit per pixel, 256 wide, scale zero: four full words
		plan.push_back('{spr_cmd(0, 0, 0, 0, 255, 0, 0, 0), 1'b0, '0});
		plan.push_back('{data_cmd('1), 1'b0, '0});
		plan.push_back('{data_cmd('0), 1'b0, '0});
		plan.push_back('{data_cmd(64'haaaa_aaaa_aaaa_aaaa), 1'b0, '0});
		plan.push_back('{data_cmd(64'h5555_5555_5555_5555), 1'b0, '0});
		// clipped at both edges, three bits per pixel, leftover bits dropped
		plan.push_back('{spr_cmd(2000, 1023, 2, 2, 255, 255, 2, 5), 1'b0, '0});
		plan.push_back('{data_cmd(64'h0123_4567_89ab_cdef), 1'b0, '0});
		plan.push_back('{data_cmd(64'hfedc_ba98_7654_3210), 1'b0, '0});
		plan.push_back('{data_cmd(64'h8000_0000_0000_0001), 1'b0, '0});
		// restart in the middle of a sprite
		plan.push_back('{spr_cmd(10, 20, 1, 2, 7, 3, 3, 31), 1'b0, '0});
		plan.push_back('{data_cmd(64'hffff_ffff_0000_0000), 1'b0, '0});
		plan.push_back('{spr_cmd(5, 5, 2, 1, 1, 0, 4, 3), 1'b0, '0});
		plan.push_back('{data_cmd(64'h3ff), 1'b0, '0});
		plan.push_back('{noise_cmd(OP_UNUSED), 1'b0, '0});

		foreach (plan[i])
			send_cmd(plan[i].c, plan[i].hand_checked, plan[i].want);

		// Random sprites: mostly complete, some cut short, some with extra words.
		while (items_done < ITEM_TARGET) begin
			if (items_done > 90)
				pressure_go = 1'b1;
			if (items_done > ITEM_TARGET - 40)
				calm = 1'b1;

			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 4))
					send_cmd(pal_cmd($urandom_range(0, 511), $urandom_range(0, 65535)));

			case ($urandom_range(0, 7))
				0:       x = SURF_W - 1 - $urandom_range(0, 20);
				1:       x = 0;
				default: x = $urandom_range(0, SURF_W - 1);
			endcase
			case ($urandom_range(0, 7))
				0:       y = SURF_H - 1 - $urandom_range(0, 10);
				1:       y = 0;
				default: y = $urandom_range(0, SURF_H - 1);
			endcase
			w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 20);
			h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
			send_cmd(spr_cmd(x, y, $urandom_range(0, 3), $urandom_range(0, 3), w, h,
				$urandom_range(0, 7), $urandom_range(0, 31)));

			// cap tall sprites; the next start abandons them
			budget = 32;
			if ($urandom_range(0, 7) == 0)
				budget = $urandom_range(0, 3);
			while (spr_active && budget > 0) begin
				send_cmd(data_cmd({$urandom, $urandom}));
				budget--;
				if ($urandom_range(0, 15) == 0)
					send_cmd(pal_cmd($urandom_range(0, 511), $urandom_range(0, 65535)));
			end

			// stray words after the sprite, or the unused opcode
			if ($urandom_range(0, 7) == 0)
				send_cmd(data_cmd({$urandom, $urandom}));
			if ($urandom_range(0, 11) == 0)
				send_cmd(noise_cmd(OP_UNUSED));
		end

		cmd_valid <= 1'b0;

		// Drain: wait for every owed pixel, then wait out any strays.
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
